@@ src/tcpw_pkg.sv @@
// tcpw_pkg: shared types and constants for the text cell pixel writer
// no dependencies; used by tcpw_ctrl, tcpw_datapath and the top level
`default_nettype none

package tcpw_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_TEXT_COLOR    = 2'd2;

    // input action codes
    localparam logic ACT_PUT_CHAR  = 1'b0;
    localparam logic ACT_LOAD_GLYPH = 1'b1;

    localparam logic [6:0]  NEWLINE_CODE = 7'd10;
    localparam logic [9:0]  COL_LIMIT    = 10'd1023;
    localparam logic [12:0] WIDTH_RESET  = 13'd0;
    localparam logic [12:0] HEIGHT_RESET = 13'd0;
    localparam logic [23:0] COLOR_RESET  = 24'hFFFFFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_WRAP_ROW,
        ST_FETCH,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic exec_load;
        logic exec_newline;
        logic exec_wrap_col;
        logic exec_wrap_row;
        logic fetch_step;
        logic emit_step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic is_load;
        logic is_newline;
        logic fetch_done;
        logic cur_bit;
        logic out_free;
        logic pos_last;
    } status_t;

endpackage

`default_nettype wire

@@ src/tcpw_ctrl.sv @@
// tcpw_ctrl: sequencing state machine for the text cell pixel writer
// depends on tcpw_pkg (state_t, cmd_t, status_t)
`default_nettype none

module tcpw_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire tcpw_pkg::status_t status,
    output tcpw_pkg::cmd_t        cmd
);

    tcpw_pkg::state_t state_reg;
    tcpw_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcpw_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            tcpw_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_done) begin
                    state_next = tcpw_pkg::ST_IDLE;
                end
            end
            tcpw_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = tcpw_pkg::ST_EXEC;
                end
            end
            tcpw_pkg::ST_EXEC: begin
                if (status.is_load) begin
                    cmd.exec_load = 1'b1;
                    state_next    = tcpw_pkg::ST_IDLE;
                end else if (status.is_newline) begin
                    cmd.exec_newline = 1'b1;
                    state_next       = tcpw_pkg::ST_IDLE;
                end else begin
                    cmd.exec_wrap_col = 1'b1;
                    state_next        = tcpw_pkg::ST_WRAP_ROW;
                end
            end
            tcpw_pkg::ST_WRAP_ROW: begin
                cmd.exec_wrap_row = 1'b1;
                state_next        = tcpw_pkg::ST_FETCH;
            end
            tcpw_pkg::ST_FETCH: begin
                cmd.fetch_step = 1'b1;
                if (status.fetch_done) begin
                    state_next = tcpw_pkg::ST_EMIT;
                end
            end
            tcpw_pkg::ST_EMIT: begin
                // a set bit waits until the output register can take it
                if (!status.cur_bit || status.out_free) begin
                    cmd.emit_step = 1'b1;
                    if (status.pos_last) begin
                        state_next = tcpw_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = tcpw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/tcpw_datapath.sv @@
// tcpw_datapath: config registers, cursor, glyph memory, pixel scan and output register
// depends on tcpw_pkg (cmd_t, status_t, constants)
`default_nettype none

module tcpw_datapath #(
    parameter int CHAR_COUNT = 128,
    parameter int MAX_SCREEN = 4096
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [23:0]       cfg_wdata,
    input  wire logic              s_action,
    input  wire logic [6:0]        s_char_code,
    input  wire logic [2:0]        s_glyph_row,
    input  wire logic [7:0]        s_row_bits,
    input  wire tcpw_pkg::cmd_t    cmd,
    output tcpw_pkg::status_t      status,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [23:0]            m_pixel_index,
    output logic [23:0]            m_pixel_color,
    output logic                   m_last_write
);

    localparam int DEPTH     = CHAR_COUNT * 8;
    localparam int AW        = $clog2(DEPTH);
    localparam int ROW_LIMIT = MAX_SCREEN / 8;
    localparam int RW        = $clog2(ROW_LIMIT + 1);
    localparam int PW        = RW + 16;

    // configuration
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [23:0] color_reg;

    // captured item
    logic        action_reg;
    logic [6:0]  code_reg;
    logic [2:0]  grow_reg;
    logic [7:0]  bits_reg;
    logic        code_ok_reg;

    // cursor
    logic [9:0]    col_reg;
    logic [RW-1:0] row_reg;

    // glyph memory
    logic [7:0]    glyph_mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [7:0]    mem_wr_data;
    logic [AW-1:0] mem_rd_addr;
    logic [10:0]   load_addr_full;
    logic [10:0]   rd_addr_full;

    // scan
    logic [3:0]    fetch_cnt_reg;
    logic [63:0]   glyph_sr_reg;
    logic [5:0]    pos_reg;
    logic [PW-1:0] prod_reg;
    logic [PW-1:0] prod_next;
    logic [23:0]   base_reg;
    logic [RW+2:0] y_pix;
    logic [12:0]   x_pix;

    // output register
    logic        m_valid_reg;
    logic [23:0] index_reg;
    logic [23:0] color_out_reg;
    logic        last_reg;
    logic        load_out;

    assign y_pix = {row_reg, 3'b000};
    assign x_pix = {col_reg, 3'b000};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= tcpw_pkg::WIDTH_RESET;
            height_reg <= tcpw_pkg::HEIGHT_RESET;
            color_reg  <= tcpw_pkg::COLOR_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tcpw_pkg::CFG_SCREEN_WIDTH:  width_reg  <= cfg_wdata[12:0];
                tcpw_pkg::CFG_SCREEN_HEIGHT: height_reg <= cfg_wdata[12:0];
                tcpw_pkg::CFG_TEXT_COLOR:    color_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg  <= s_action;
            code_reg    <= s_char_code;
            grow_reg    <= s_glyph_row;
            bits_reg    <= s_row_bits;
            code_ok_reg <= 32'(s_char_code) < 32'(CHAR_COUNT);
        end
    end

    // cursor update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            if (cmd.exec_newline) begin
                col_reg <= '0;
                if (32'(row_reg) < 32'(ROW_LIMIT)) begin
                    row_reg <= row_reg + 1'b1;
                end
            end
            if (cmd.exec_wrap_col && (x_pix >= width_reg)) begin
                col_reg <= '0;
                if (32'(row_reg) < 32'(ROW_LIMIT)) begin
                    row_reg <= row_reg + 1'b1;
                end
            end
            if (cmd.exec_wrap_row && (32'(y_pix) >= 32'(height_reg))) begin
                row_reg <= '0;
            end
            if (cmd.emit_step && (pos_reg == 6'd63) && (col_reg < tcpw_pkg::COL_LIMIT)) begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // clearing pass counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // memory port selection
    assign load_addr_full = {1'b0, code_reg, grow_reg};
    assign rd_addr_full   = {1'b0, code_reg, fetch_cnt_reg[2:0]};
    assign mem_rd_addr    = rd_addr_full[AW-1:0];

    always_comb begin
        if (cmd.clear_step) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_reg;
            mem_wr_data = '0;
        end else begin
            mem_wr_en   = cmd.exec_load && code_ok_reg;
            mem_wr_addr = load_addr_full[AW-1:0];
            mem_wr_data = bits_reg;
        end
    end

    // glyph memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            glyph_mem[mem_wr_addr] <= mem_wr_data;
        end
        rd_data_reg <= glyph_mem[mem_rd_addr];
    end

    // row base: y * width + x, then plus width per glyph row
    assign prod_next = PW'(y_pix) * PW'(width_reg);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (cmd.fetch_step) begin
            base_reg <= 24'(prod_reg) + 24'(x_pix);
        end else if (cmd.emit_step && (pos_reg[2:0] == 3'd7)) begin
            base_reg <= base_reg + 24'(width_reg);
        end
    end

    // glyph fetch into shift register, then one pixel position per step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fetch_cnt_reg <= '0;
            pos_reg       <= '0;
        end else begin
            if (cmd.fetch_step) begin
                fetch_cnt_reg <= (fetch_cnt_reg == 4'd8) ? 4'd0 : fetch_cnt_reg + 4'd1;
            end
            if (cmd.emit_step) begin
                pos_reg <= pos_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fetch_step && (fetch_cnt_reg != 4'd0)) begin
            glyph_sr_reg <= {(code_ok_reg ? rd_data_reg : 8'h00), glyph_sr_reg[63:8]};
        end else if (cmd.emit_step) begin
            glyph_sr_reg <= {1'b0, glyph_sr_reg[63:1]};
        end
    end

    // output register
    assign load_out = cmd.emit_step && glyph_sr_reg[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            index_reg     <= base_reg + 24'(pos_reg[2:0]);
            color_out_reg <= color_reg;
            last_reg      <= (glyph_sr_reg[63:1] == '0);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_index = index_reg;
    assign m_pixel_color = color_out_reg;
    assign m_last_write  = last_reg;

    // status
    assign status.clear_done = (clr_cnt_reg == AW'(DEPTH - 1));
    assign status.is_load    = (action_reg == tcpw_pkg::ACT_LOAD_GLYPH);
    assign status.is_newline = (code_reg == tcpw_pkg::NEWLINE_CODE);
    assign status.fetch_done = (fetch_cnt_reg == 4'd8);
    assign status.cur_bit    = glyph_sr_reg[0];
    assign status.out_free   = !m_valid_reg || m_ready;
    assign status.pos_last   = (pos_reg == 6'd63);

endmodule

`default_nettype wire

@@ src/text_cell_pixel_writer_top.sv @@
// text_cell_pixel_writer_top: 8x8 character generator writing glyph pixels to a framebuffer
// depends on tcpw_pkg, tcpw_ctrl, tcpw_datapath
//
// Usage:
//   s_ channel carries one item: a glyph row load (action 1) or a character to print.
//   m_ channel carries one framebuffer write per set glyph pixel, row-major in the
//   cell, with m_last_write on the final write of the character.
//   cfg_wr_en/cfg_index/cfg_wdata write screen width, height and text color;
//   write them only while the block is idle.
// Sequence:
//   after reset the glyph memory is cleared with s_ready low.
//   a glyph load or a newline is carried out in the EXEC state; a printed character goes
//   through transfer, 2 decode states, glyph fetch from the single memory read port and
//   64 pixel positions scanned one per cycle while a set pixel finds the output free.
//   a stalled receiver holds the scan at the next set pixel; the output register
//   lets the last write wait while the next item is taken.
// Reset: synchronous active low; cursor goes to the top left, width and height to 0,
//   color to white.
`default_nettype none

module text_cell_pixel_writer_top #(
    parameter int CHAR_COUNT = 128,
    parameter int MAX_SCREEN = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [6:0]  s_char_code,
    input  wire logic [2:0]  s_glyph_row,
    input  wire logic [7:0]  s_row_bits,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [23:0]      m_pixel_index,
    output logic [23:0]      m_pixel_color,
    output logic             m_last_write
);

    tcpw_pkg::cmd_t    cmd;
    tcpw_pkg::status_t status;

    // sequencer
    tcpw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath
    tcpw_datapath #(
        .CHAR_COUNT (CHAR_COUNT),
        .MAX_SCREEN (MAX_SCREEN)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_action      (s_action),
        .s_char_code   (s_char_code),
        .s_glyph_row   (s_glyph_row),
        .s_row_bits    (s_row_bits),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_index (m_pixel_index),
        .m_pixel_color (m_pixel_color),
        .m_last_write  (m_last_write)
    );

`ifndef SYNTHESIS
    // no pixel write can be pending while the glyph memory is being cleared
    a_clear_no_output: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_step |-> !m_valid)
        else $error("output valid during clearing pass");

    // a set pixel never overwrites a stalled result
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_step && status.cur_bit) |-> status.out_free)
        else $error("pixel write dropped on stalled output");

    // one item at a time: the cycle after a transfer the input is closed
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> !s_ready)
        else $error("input reopened right after transfer");
`endif

endmodule

`default_nettype wire

@@ test/tcpw_pixel_checker.sv @@
`timescale 1ns / 1ps
// tcpw_pixel_checker: watches the cfg, s_ and m_ ports of the text cell pixel writer,
// predicts each pixel write and compares it with the m_ transfers; depends on tcpw_pkg
`default_nettype none

module tcpw_pixel_checker #(
    parameter int CHAR_COUNT = 128,
    parameter int MAX_SCREEN = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_wdata,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_action,
    input  wire logic [6:0]  s_char_code,
    input  wire logic [2:0]  s_glyph_row,
    input  wire logic [7:0]  s_row_bits,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [23:0] m_pixel_index,
    input  wire logic [23:0] m_pixel_color,
    input  wire logic        m_last_write,
    output int unsigned      error_count,
    output int unsigned      writes_pending
);

    localparam int CELL      = 8;
    localparam int ROW_LIMIT = MAX_SCREEN / CELL;

    typedef struct packed {
        logic [23:0] index;
        logic [23:0] color;
        logic        last;
    } pixel_write_t;

    // shadow of the block's registers and cursor
    logic [12:0]  scr_width;
    logic [12:0]  scr_height;
    logic [23:0]  txt_color;
    logic [9:0]   cur_col;
    logic [9:0]   cur_row;
    logic [7:0]   glyph_mem [CHAR_COUNT*8];
    pixel_write_t writes_due [$];

    // row advance saturates at ROW_LIMIT, one past the last cell row
    task automatic advance_row();
        if (int'(cur_row) < ROW_LIMIT)
            cur_row = cur_row + 10'd1;
    endtask

    // cursor update and pixel writes caused by one input transfer
    task automatic predict_pixel_writes(input logic act, input logic [6:0] code,
                                        input logic [2:0] grow, input logic [7:0] bits);
        longint unsigned x;
        longint unsigned y;
        longint unsigned idx;
        logic [7:0]      g;
        int              base;
        int              total;
        int              n;
        pixel_write_t    pw;
        base = int'(code) * CELL;
        if (act == tcpw_pkg::ACT_LOAD_GLYPH) begin
            if (int'(code) < CHAR_COUNT)
                glyph_mem[base + int'(grow)] = bits;
        end else if (code == tcpw_pkg::NEWLINE_CODE) begin
            cur_col = '0;
            advance_row();
        end else begin
            // wrap column, then row, before drawing
            if (longint'(cur_col) * CELL >= longint'(scr_width)) begin
                cur_col = '0;
                advance_row();
            end
            if (longint'(cur_row) * CELL >= longint'(scr_height))
                cur_row = '0;
            x = longint'(cur_col) * CELL;
            y = longint'(cur_row) * CELL;
            if (int'(code) < CHAR_COUNT) begin
                total = 0;
                for (int r = 0; r < CELL; r++)
                    total += $countones(glyph_mem[base + r]);
                n = 0;
                for (int r = 0; r < CELL; r++) begin
                    g = glyph_mem[base + r];
                    for (int c = 0; c < CELL; c++) begin
                        if (g[c]) begin
                            n++;
                            idx = (y + r) * longint'(scr_width) + x + c;
                            pw.index = idx[23:0];
                            pw.color = txt_color;
                            pw.last  = (n == total);
                            writes_due.push_back(pw);
                        end
                    end
                end
            end
            if (cur_col < tcpw_pkg::COL_LIMIT)
                cur_col = cur_col + 10'd1;
        end
    endtask

    always @(posedge aclk) begin
        pixel_write_t want;
        if (!aresetn) begin
            scr_width   = tcpw_pkg::WIDTH_RESET;
            scr_height  = tcpw_pkg::HEIGHT_RESET;
            txt_color   = tcpw_pkg::COLOR_RESET;
            cur_col     = '0;
            cur_row     = '0;
            error_count = 0;
            for (int i = 0; i < CHAR_COUNT * CELL; i++)
                glyph_mem[i] = '0;
            writes_due.delete();
        end else begin
            // compare each write transfer with the oldest prediction
            if (m_valid && m_ready) begin
                if (writes_due.size() == 0) begin
                    $error("unexpected pixel write: index %0d color %h",
                           m_pixel_index, m_pixel_color);
                    error_count++;
                end else begin
                    want = writes_due.pop_front();
                    if (m_pixel_index !== want.index) begin
                        $error("pixel_index: expected %0d, actual %0d",
                               want.index, m_pixel_index);
                        error_count++;
                    end
                    if (m_pixel_color !== want.color) begin
                        $error("pixel_color: expected %h, actual %h",
                               want.color, m_pixel_color);
                        error_count++;
                    end
                    if (m_last_write !== want.last) begin
                        $error("last_write: expected %0b, actual %0b",
                               want.last, m_last_write);
                        error_count++;
                    end
                end
            end
            // register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    tcpw_pkg::CFG_SCREEN_WIDTH:  scr_width  = cfg_wdata[12:0];
                    tcpw_pkg::CFG_SCREEN_HEIGHT: scr_height = cfg_wdata[12:0];
                    tcpw_pkg::CFG_TEXT_COLOR:    txt_color  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_pixel_writes(s_action, s_char_code, s_glyph_row, s_row_bits);
        end
        writes_pending <= writes_due.size();
    end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// testbench: drives glyph loads and text through the text cell pixel writer under
// several screen settings; depends on tcpw_pkg, text_cell_pixel_writer_top, tcpw_pixel_checker
`default_nettype none

module testbench;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_index   = tcpw_pkg::CFG_SCREEN_WIDTH;
    logic [23:0] cfg_wdata   = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_action    = tcpw_pkg::ACT_PUT_CHAR;
    logic [6:0]  s_char_code = '0;
    logic [2:0]  s_glyph_row = '0;
    logic [7:0]  s_row_bits  = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [23:0] m_pixel_index;
    logic [23:0] m_pixel_color;
    logic        m_last_write;

    int unsigned error_count;
    int unsigned writes_pending;

    // stimulus control
    logic steady   = 1'b0;
    logic hold_req = 1'b0;
    int   pool_base = 0;
    int   items_sent = 0;

    always #5 aclk = ~aclk;

    text_cell_pixel_writer_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_char_code   (s_char_code),
        .s_glyph_row   (s_glyph_row),
        .s_row_bits    (s_row_bits),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_index (m_pixel_index),
        .m_pixel_color (m_pixel_color),
        .m_last_write  (m_last_write)
    );

    tcpw_pixel_checker pixel_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_char_code    (s_char_code),
        .s_glyph_row    (s_glyph_row),
        .s_row_bits     (s_row_bits),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_index  (m_pixel_index),
        .m_pixel_color  (m_pixel_color),
        .m_last_write   (m_last_write),
        .error_count    (error_count),
        .writes_pending (writes_pending)
    );

    // one input transfer, with random idle cycles ahead of it unless steady is set
    task automatic send_item(input logic act, input logic [6:0] code,
                             input logic [2:0] grow, input logic [7:0] bits);
        if (!steady) begin
            while ($urandom_range(99) < 34) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_char_code <= code;
        s_glyph_row <= grow;
        s_row_bits  <= bits;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        items_sent++;
    endtask

    // print a character; the load fields carry junk
    task automatic send_print(input logic [6:0] code);
        send_item(tcpw_pkg::ACT_PUT_CHAR, code, 3'($urandom), 8'($urandom));
    endtask

    task automatic send_newline();
        send_item(tcpw_pkg::ACT_PUT_CHAR, tcpw_pkg::NEWLINE_CODE, 3'($urandom), 8'($urandom));
    endtask

    // glyph row with a random density
    function automatic logic [7:0] glyph_byte();
        case ($urandom_range(4))
            0:       return 8'hFF;
            1:       return 8'h00;
            2:       return 8'h01 << $urandom_range(7);
            3:       return 8'($urandom) & 8'($urandom);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [6:0] pool_code();
        return 7'(pool_base + $urandom_range(7));
    endfunction

    // mostly glyph definitions and lines of text, some junk transfers
    task automatic send_text(input int count);
        int         start;
        int         roll;
        logic [6:0] code;
        start = items_sent;
        pool_base = $urandom_range(120);
        while (items_sent - start < count) begin
            roll = $urandom_range(99);
            if (roll < 30) begin
                code = pool_code();
                for (int r = 0; r < 8; r++)
                    send_item(tcpw_pkg::ACT_LOAD_GLYPH, code, 3'(r), glyph_byte());
                repeat ($urandom_range(1, 2)) send_print(code);
            end else if (roll < 88) begin
                repeat ($urandom_range(1, 5)) send_print(pool_code());
                if ($urandom_range(1))
                    send_newline();
            end else begin
                send_item(1'($urandom), 7'($urandom), 3'($urandom), 8'($urandom));
            end
        end
    endtask

    // drain all predicted writes, then let a blank glyph finish its scan
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (writes_pending != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic set_screen(input logic [12:0] w, input logic [12:0] h,
                              input logic [23:0] color);
        cfg_wr_en <= 1'b1;
        cfg_index <= tcpw_pkg::CFG_SCREEN_WIDTH;
        cfg_wdata <= 24'(w);
        @(posedge aclk);
        cfg_index <= tcpw_pkg::CFG_SCREEN_HEIGHT;
        cfg_wdata <= 24'(h);
        @(posedge aclk);
        cfg_index <= tcpw_pkg::CFG_TEXT_COLOR;
        cfg_wdata <= color;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 34);
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values: zero width and height, white text
        send_print(7'd65);                      // blank glyph, no writes
        send_item(tcpw_pkg::ACT_LOAD_GLYPH, 7'd65, 3'd0, 8'h01);
        send_item(tcpw_pkg::ACT_LOAD_GLYPH, 7'd65, 3'd1, 8'h80);
        send_item(tcpw_pkg::ACT_LOAD_GLYPH, 7'd65, 3'd2, 8'hAA);
        send_item(tcpw_pkg::ACT_LOAD_GLYPH, 7'd65, 3'd3, 8'h55);
        send_item(tcpw_pkg::ACT_LOAD_GLYPH, 7'd65, 3'd4, 8'h00);
        send_item(tcpw_pkg::ACT_LOAD_GLYPH, 7'd65, 3'd5, 8'hFF);
        send_item(tcpw_pkg::ACT_LOAD_GLYPH, 7'd65, 3'd6, 8'h18);
        send_item(tcpw_pkg::ACT_LOAD_GLYPH, 7'd65, 3'd7, 8'h81);
        send_print(7'd65);
        send_newline();
        for (int r = 0; r < 8; r++)
            send_item(tcpw_pkg::ACT_LOAD_GLYPH, 7'd127, 3'(r), 8'hFF);
        send_print(7'd127);                     // full cell, most writes
        send_item(tcpw_pkg::ACT_LOAD_GLYPH, 7'd0, 3'd0, 8'h01);
        send_print(7'd0);
        send_item(tcpw_pkg::ACT_LOAD_GLYPH, tcpw_pkg::NEWLINE_CODE, 3'd3, 8'hFF);
        send_print(tcpw_pkg::NEWLINE_CODE);     // still a newline, never drawn
        send_print(7'd0);                       // zero height puts the row back at 0
        settle();

        // wide screen, short height: walk the cursor to the bottom row, then past it
        set_screen(13'd4096, 13'd160, 24'($urandom));
        repeat (19) send_newline();
        send_print(7'd127);                     // last cell row that fits
        repeat (3) send_newline();
        send_print(7'd127);                     // wraps back to the top
        hold_req <= 1'b1;
        send_text(60);
        settle();

        // one cell screen, black text, no idling
        set_screen(13'd8, 13'd8, 24'h000000);
        steady <= 1'b1;
        send_text(40);
        settle();
        steady <= 1'b0;

        // sizes that are not whole cells
        set_screen(13'd100, 13'd37, 24'hFFFFFF);
        send_text(50);
        settle();

        set_screen(13'd0, 13'd4095, 24'($urandom));
        send_text(30);
        settle();

        set_screen(13'd4095, 13'd0, 24'($urandom));
        send_text(30);
        settle();

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial begin
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
src/tcpw_pkg.sv
src/tcpw_ctrl.sv
src/tcpw_datapath.sv
src/text_cell_pixel_writer_top.sv
test/tcpw_pixel_checker.sv
test/testbench.sv
